// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file trm_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define ASSERT_CLKD(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("token ring node assertion failed");

// Checked on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("token ring node assertion failed");

`endif

// ===== rtl/trm_pkg.sv =====
package trm_pkg;

   localparam logic [3:0] MAX_NODES = 4'd8;
   localparam int ADDR_WIDTH = 4;

   typedef enum logic [2:0] {
      CMD_START         = 3'd0,
      CMD_TICK          = 3'd1,
      CMD_TOKEN_ARRIVED = 3'd2,
      CMD_CLIENT_REQ    = 3'd3,
      CMD_CLIENT_REL    = 3'd4,
      CMD_SEND_FAILED   = 3'd5,
      CMD_SEARCH_RESULT = 3'd6,
      CMD_HOLDER_QUERY  = 3'd7
   } cmd_type;

   typedef enum logic [2:0] {
      ACT_ACK    = 3'd0,
      ACT_SEND   = 3'd1,
      ACT_SEARCH = 3'd2,
      ACT_ACCESS = 3'd3,
      ACT_QUERY  = 3'd4
   } act_type;

   typedef enum logic [1:0] {
      REG_LOCAL_NODE    = 2'd0,
      REG_NODES_IN_USE  = 2'd1,
      REG_TIMEOUT_TICKS = 2'd2
   } reg_idx_type;

   typedef struct packed {
      logic [2:0] local_node;
      logic [3:0] nodes_in_use;
      logic [7:0] timeout_ticks;
   } cfg_type;

   typedef struct packed {
      act_type    action;
      logic [2:0] target_node;
      logic       answer;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      logic    two;
      rsp_type first;
      rsp_type second;
   } push_type;

   function automatic logic [3:0] ring_size(logic [3:0] nodes);
      return (nodes > MAX_NODES) ? MAX_NODES : nodes;
   endfunction

   function automatic logic [2:0] next_of(logic [2:0] node, logic [3:0] size);
      logic [3:0] nx;
      nx = {1'b0, node} + 4'd1;
      return (nx >= size) ? 3'd0 : nx[2:0];
   endfunction

   function automatic logic [7:0] ring_mask(logic [3:0] size);
      logic [7:0] m;
      for (int i = 0; i < 8; i++) begin
         m[i] = (4'(i) < size);
      end
      return m;
   endfunction

   function automatic logic [2:0] lowest_set(logic [7:0] r);
      logic [2:0] low;
      low = 3'd7;
      for (int i = 6; i >= 0; i--) begin
         if (r[i]) begin
            low = 3'(i);
         end
      end
      return low;
   endfunction

endpackage

// ===== rtl/token_ring_mutex_node.sv =====
// Channel   Direction  Payload
// req_      in         tuser: command[2:0]; tdata: reachable_mask[7:0], holder_mask[15:8]
// rsp_      out        tuser: action[2:0]; tdata: target_node[2:0], answer[3]; tlast: last
// csr_      in         APB writes and reads of local_node, nodes_in_use, timeout_ticks
//
// A request is registered and then processed, so one request per cycle is
// taken while the four-entry result queue has room for two more results.
// A request yields one or two results; the result port drains one per cycle while rsp_tready is high.
// Reset is synchronous and restores the register defaults and clears all node state.
// A stalled result port fills the queue and then holds off req_tready.
module token_ring_mutex_node
   import trm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [15:0]           req_tdata,  // reachable_mask[7:0], holder_mask[15:8]
   input  logic [2:0]            req_tuser,  // command[2:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,  // target_node[2:0], answer[3], zero[7:4]
   output logic [2:0]            rsp_tuser,  // action[2:0]
   output logic                  rsp_tlast,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [ADDR_WIDTH-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   cfg_type    cfg;
   push_type   push;
   rsp_type    head;
   logic       room;
   logic       fire;
   logic       in_valid_ff;
   cmd_type    cmd_ff;
   logic [7:0] reach_ff;
   logic [7:0] hold_ff;

   assign fire       = in_valid_ff && room;
   assign req_tready = !in_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         cmd_ff   <= cmd_type'(req_tuser);
         reach_ff <= req_tdata[7:0];
         hold_ff  <= req_tdata[15:8];
      end
   end

   trm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   trm_core u_core (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .fire  (fire),
      .cmd   (cmd_ff),
      .reach (reach_ff),
      .hold  (hold_ff),
      .push  (push)
   );

   trm_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (rsp_tready),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_data  (head)
   );

   assign rsp_tuser = head.action;
   assign rsp_tdata = {4'd0, head.answer, head.target_node};
   assign rsp_tlast = head.last;

endmodule

// ===== rtl/trm_csr.sv =====
module trm_csr
   import trm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [ADDR_WIDTH-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   reg_idx_type idx;
   logic        wr_en;

   assign csr_pready = 1'b1;
   assign idx        = reg_idx_type'(csr_paddr[ADDR_WIDTH-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_LOCAL_NODE:    cfg_in.local_node    = csr_pwdata[2:0];
            REG_NODES_IN_USE:  cfg_in.nodes_in_use  = csr_pwdata[3:0];
            REG_TIMEOUT_TICKS: cfg_in.timeout_ticks = csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_LOCAL_NODE:    csr_prdata = {29'd0, cfg_ff.local_node};
         REG_NODES_IN_USE:  csr_prdata = {28'd0, cfg_ff.nodes_in_use};
         REG_TIMEOUT_TICKS: csr_prdata = {24'd0, cfg_ff.timeout_ticks};
         default:           csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.local_node    <= 3'd0;
         cfg_ff.nodes_in_use  <= 4'd3;
         cfg_ff.timeout_ticks <= 8'd30;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/trm_core.sv =====
module trm_core
   import trm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       fire,
   input  cmd_type    cmd,
   input  logic [7:0] reach,
   input  logic [7:0] hold,
   output push_type   push
);

   logic       holds_ff, holds_in;
   logic       wants_ff, wants_in;
   logic [7:0] idle_ff, idle_in;
   logic [2:0] succ_ff, succ_in;
   logic       early_ff, early_in;

   logic [3:0] size;
   logic [7:0] r;
   logic       a_valid, b_valid;
   rsp_type    a, b, ack;

   assign size = ring_size(cfg.nodes_in_use);
   assign r    = reach & ring_mask(size);

   always_comb begin
      holds_in = holds_ff;
      wants_in = wants_ff;
      idle_in  = idle_ff;
      succ_in  = succ_ff;
      early_in = early_ff;
      a_valid  = 1'b0;
      b_valid  = 1'b0;
      a        = '{action: ACT_ACK, target_node: 3'd0, answer: 1'b0, last: 1'b0};
      b        = a;
      ack      = a;
      case (cmd)
         CMD_START: begin
            succ_in = next_of(cfg.local_node, size);
            if (cfg.local_node == 3'd0 || early_ff) begin
               holds_in = 1'b1;
               early_in = 1'b0;
            end else begin
               holds_in = 1'b0;
            end
            wants_in = 1'b0;
            idle_in  = 8'd0;
         end
         CMD_TICK: begin
            if (idle_ff < cfg.timeout_ticks) begin
               idle_in = holds_ff ? 8'd0 : idle_ff + 8'd1;
            end else begin
               idle_in  = 8'd0;
               a_valid  = 1'b1;
               a.action = ACT_SEARCH;
            end
            if (holds_ff && !wants_ff) begin
               holds_in      = 1'b0;
               b_valid       = 1'b1;
               b.action      = ACT_SEND;
               b.target_node = succ_ff;
            end
         end
         CMD_TOKEN_ARRIVED: begin
            early_in = 1'b1;
            holds_in = 1'b1;
         end
         CMD_CLIENT_REQ: begin
            wants_in = 1'b1;
            a_valid  = 1'b1;
            a.action = ACT_ACCESS;
            a.answer = holds_ff;
         end
         CMD_CLIENT_REL: begin
            wants_in = 1'b0;
         end
         CMD_SEND_FAILED: begin
            succ_in       = next_of(succ_ff, size);
            a_valid       = 1'b1;
            a.action      = ACT_SEND;
            a.target_node = succ_in;
         end
         CMD_SEARCH_RESULT: begin
            if ((r & hold) == 8'd0 && r != 8'd0 && lowest_set(r) == cfg.local_node) begin
               if (wants_ff) begin
                  holds_in = 1'b1;
               end else begin
                  holds_in      = 1'b0;
                  a_valid       = 1'b1;
                  a.action      = ACT_SEND;
                  a.target_node = succ_ff;
               end
            end
         end
         default: begin
            a_valid  = 1'b1;
            a.action = ACT_QUERY;
            a.answer = holds_ff;
         end
      endcase

      push.valid = fire;
      push.two   = a_valid && b_valid;
      if (a_valid) begin
         push.first  = a;
         push.second = b;
      end else if (b_valid) begin
         push.first  = b;
         push.second = b;
      end else begin
         push.first  = ack;
         push.second = ack;
      end
      push.first.last  = !push.two;
      push.second.last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         holds_ff <= 1'b0;
         wants_ff <= 1'b0;
         idle_ff  <= 8'd0;
         succ_ff  <= 3'd0;
         early_ff <= 1'b0;
      end else if (fire) begin
         holds_ff <= holds_in;
         wants_ff <= wants_in;
         idle_ff  <= idle_in;
         succ_ff  <= succ_in;
         early_ff <= early_in;
      end
   end

endmodule

// ===== rtl/trm_outq.sv =====
module trm_outq
   import trm_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   input  logic     pop,
   output logic     room,
   output logic     out_valid,
   output rsp_type  out_data
);

   rsp_type    entry_ff [4];
   logic [1:0] head_ff, head_in;
   logic [1:0] tail_ff, tail_in;
   logic [2:0] count_ff, count_in;
   logic [2:0] after_pop;
   logic [2:0] n_push;
   logic       do_pop;

   assign out_valid = (count_ff != 3'd0);
   assign out_data  = entry_ff[head_ff];
   assign do_pop    = pop && out_valid;
   assign after_pop = count_ff - {2'd0, do_pop};
   assign room      = (after_pop <= 3'd2);
   assign n_push    = push.valid ? (push.two ? 3'd2 : 3'd1) : 3'd0;

   always_comb begin
      head_in  = head_ff + {1'b0, do_pop};
      tail_in  = tail_ff + n_push[1:0];
      count_in = after_pop + n_push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= 2'd0;
         tail_ff  <= 2'd0;
         count_ff <= 3'd0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entry_ff[tail_ff] <= push.first;
         if (push.two) begin
            entry_ff[tail_ff + 2'd1] <= push.second;
         end
      end
   end

endmodule

// ===== rtl/trm_checker.sv =====
`include "assert_macros.svh"

module trm_checker
   import trm_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [2:0] rsp_tuser,
   input logic       rsp_tlast
);

   `ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid)
   `ASSERT_CLKD(a_stall_hold, clock, reset,
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
   `ASSERT_CLKD(a_target_only_send, clock, reset,
      rsp_tvalid && rsp_tuser != ACT_SEND |-> rsp_tdata[2:0] == 3'd0)
   `ASSERT_CLKD(a_search_then_send, clock, reset,
      rsp_tvalid && !rsp_tlast |-> rsp_tuser == ACT_SEARCH)

endmodule

bind token_ring_mutex_node trm_checker u_trm_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
